@@ design/q4bdq_pkg.sv @@
package q4bdq_pkg;

  localparam int FIELD_LANES = 8;
  localparam int NIB_W = 4;
  localparam int WEIGHT_W = 5;
  localparam int ACT_W = 16;
  localparam int SCALE_W = 16;
  localparam int PROD_W = 20;
  localparam int DOT_W = 23;
  localparam int SCALED_W = DOT_W + SCALE_W;
  localparam int SCALE_SHIFT = 12;
  localparam int TERM_W = SCALED_W - SCALE_SHIFT;
  localparam int ACC_W = 48;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_OFFSET = 5'sd8;

  typedef struct packed {
    logic [31:0]              weight_nibbles;
    logic signed [ACT_W-1:0]  act_0;
    logic signed [ACT_W-1:0]  act_1;
    logic signed [ACT_W-1:0]  act_2;
    logic signed [ACT_W-1:0]  act_3;
    logic signed [ACT_W-1:0]  act_4;
    logic signed [ACT_W-1:0]  act_5;
    logic signed [ACT_W-1:0]  act_6;
    logic signed [ACT_W-1:0]  act_7;
    logic signed [SCALE_W-1:0] block_scale;
    logic                     last_of_row;
  } item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] row_sum;
    logic                    overflow;
  } result_t;

  function automatic logic signed [ACT_W-1:0] act_of(input item_t it, input int k);
    logic signed [ACT_W-1:0] a;
    case (k)
      0: a = it.act_0;
      1: a = it.act_1;
      2: a = it.act_2;
      3: a = it.act_3;
      4: a = it.act_4;
      5: a = it.act_5;
      6: a = it.act_6;
      7: a = it.act_7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ design/q4bdq_lane.sv @@
module q4bdq_lane (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [q4bdq_pkg::NIB_W-1:0]           nibble,
  input  logic signed [q4bdq_pkg::ACT_W-1:0]    act,
  output logic signed [q4bdq_pkg::PROD_W-1:0]   prod
);

  logic signed [q4bdq_pkg::WEIGHT_W-1:0] weight;
  logic signed [q4bdq_pkg::PROD_W-1:0]   full;

  assign weight = $signed({1'b0, nibble}) - q4bdq_pkg::WEIGHT_OFFSET;
  assign full = weight * act;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full;
    end
  end

endmodule

@@ design/q4bdq_merge.sv @@
module q4bdq_merge #(
  parameter int NLANES = 8
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [q4bdq_pkg::PROD_W-1:0]   prod [NLANES],
  input  logic signed [q4bdq_pkg::SCALE_W-1:0]  scale,
  output logic signed [q4bdq_pkg::TERM_W-1:0]   term
);

  logic signed [q4bdq_pkg::DOT_W-1:0]    dot_next;
  logic signed [q4bdq_pkg::DOT_W-1:0]    dot;
  logic signed [q4bdq_pkg::SCALE_W-1:0]  scale_q;
  logic signed [q4bdq_pkg::SCALED_W-1:0] scaled;

  always_comb begin
    dot_next = '0;
    for (int k = 0; k < NLANES; k++) begin
      dot_next = dot_next + q4bdq_pkg::DOT_W'(prod[k]);
    end
  end

  assign scaled = dot * scale_q;

  always_ff @(posedge clk) begin
    if (en) begin
      dot     <= dot_next;
      scale_q <= scale;
      term    <= scaled[q4bdq_pkg::SCALED_W-1:q4bdq_pkg::SCALE_SHIFT];
    end
  end

endmodule

@@ design/q4_block_dequant_dot_product_top.sv @@
// Q4 block dot product. Each transaction on the item channel carries eight
// packed 4-bit weights, eight Q8.8 activations, the Q4.12 block scale and
// a row-end mark. The lanes form (nibble - 8) * activation, the merge stage
// sums them, applies the scale and shifts right by 12, and the result is
// added into a 48-bit saturating row accumulator.
// A transaction on the result channel appears only for an item with
// last_of_row set; it carries the row sum and the sticky overflow flag,
// and the accumulator and flag clear behind it.
// Throughput: one item per cycle unless the pipeline holds for a stalled
// receiver; the pipeline is lane products, lane sum, scale multiply and
// accumulate, each one register deep.
// When the result register is full and the receiver stalls, the whole
// pipeline holds and item_stall is raised; the held result does not change.
// Reset clears all valid bits, the accumulator and the overflow flag.
module q4_block_dequant_dot_product_top #(
  parameter int LANES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  q4bdq_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_stall,
  output q4bdq_pkg::result_t  result
);

  localparam int USED = (LANES < q4bdq_pkg::FIELD_LANES) ? LANES : q4bdq_pkg::FIELD_LANES;

  logic advance;
  logic take;
  logic s1_valid, s1_last;
  logic s2_valid, s2_last;
  logic s3_valid, s3_last;
  logic signed [q4bdq_pkg::SCALE_W-1:0] s1_scale;
  logic signed [q4bdq_pkg::PROD_W-1:0]  prod [USED];
  logic signed [q4bdq_pkg::TERM_W-1:0]  term;
  logic signed [q4bdq_pkg::ACC_W-1:0]   acc;
  logic                                 ovf_seen;
  logic signed [q4bdq_pkg::ACC_W:0]     sum_wide;
  logic signed [q4bdq_pkg::ACC_W-1:0]   acc_next;
  logic                                 sat_hit;

  assign advance    = !(result_valid && result_stall);
  assign item_stall = !advance;
  assign take       = item_valid && advance;

  for (genvar k = 0; k < USED; k++) begin : g_lane
    q4bdq_lane u_lane (
      .clk    (clk),
      .en     (advance),
      .nibble (item.weight_nibbles[q4bdq_pkg::NIB_W*k +: q4bdq_pkg::NIB_W]),
      .act    (q4bdq_pkg::act_of(item, k)),
      .prod   (prod[k])
    );
  end

  q4bdq_merge #(
    .NLANES (USED)
  ) u_merge (
    .clk   (clk),
    .en    (advance),
    .prod  (prod),
    .scale (s1_scale),
    .term  (term)
  );

  assign sum_wide = {acc[q4bdq_pkg::ACC_W-1], acc} + (q4bdq_pkg::ACC_W+1)'(term);
  assign sat_hit  = sum_wide[q4bdq_pkg::ACC_W] != sum_wide[q4bdq_pkg::ACC_W-1];

  always_comb begin
    if (!sat_hit) begin
      acc_next = sum_wide[q4bdq_pkg::ACC_W-1:0];
    end else if (sum_wide[q4bdq_pkg::ACC_W]) begin
      acc_next = {1'b1, {(q4bdq_pkg::ACC_W-1){1'b0}}};
    end else begin
      acc_next = {1'b0, {(q4bdq_pkg::ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_scale <= item.block_scale;
      s1_last  <= item.last_of_row;
      s2_last  <= s1_last;
      s3_last  <= s2_last;
      if (s3_valid && s3_last) begin
        result.row_sum  <= acc_next;
        result.overflow <= ovf_seen || sat_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
      acc          <= '0;
      ovf_seen     <= 1'b0;
    end else if (advance) begin
      s1_valid     <= take;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      result_valid <= s3_valid && s3_last;
      if (s3_valid) begin
        if (s3_last) begin
          acc      <= '0;
          ovf_seen <= 1'b0;
        end else begin
          acc      <= acc_next;
          ovf_seen <= ovf_seen || sat_hit;
        end
      end
    end
  end

  a_row_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && s3_valid && s3_last) |=> (acc == '0 && !ovf_seen))
    else $error("row state not cleared after row end");

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    (advance && s3_valid && sat_hit) |=> (ovf_seen || result.overflow))
    else $error("saturation did not set the overflow flag");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s3_valid && s3_last))
    else $error("result raised without a row-end item");

endmodule
